### rtl/pea_pkg.sv
`default_nettype none
package pea_pkg;

  typedef enum logic [1:0] {
    KIND_ALLOC = 2'd0,
    KIND_CLAIM = 2'd1,
    KIND_FREE  = 2'd2,
    KIND_RESET = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_INVALID = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

endpackage
`default_nettype wire

### rtl/pea_ram.sv
`default_nettype none
module pea_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/pea_engine.sv
`default_nettype none
module pea_engine
  import pea_pkg::*;
#(
  parameter int TABLE_DEPTH = 128,
  parameter int PAGE_BITS   = 40
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 req_valid,
  output logic                      req_ready,
  input  wire logic [1:0]           req_kind,
  input  wire logic [PAGE_BITS-1:0] req_start,
  input  wire logic [PAGE_BITS:0]   req_end,
  input  wire logic [PAGE_BITS:0]   req_count,
  output logic                      rsp_valid,
  input  wire logic                 rsp_ready,
  output logic [PAGE_BITS-1:0]      rsp_base,
  output logic [1:0]                rsp_status,
  output logic [PAGE_BITS+1:0]      rsp_used,
  output logic [PAGE_BITS:0]        rsp_free,
  output logic [PAGE_BITS:0]        rsp_top
);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = 2 * PAGE_BITS + 1;
  localparam logic [PAGE_BITS:0] PAGE_LIMIT = {1'b1, {PAGE_BITS{1'b0}}};

  // One entry holds start and end; the page count is always end minus start.
  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_WR, S_APPEND, S_SHIFT_RD, S_SHIFT_WR, S_DONE
  } state_t;

  state_t                  state_r;
  logic [1:0]              kind_r;
  logic [PAGE_BITS-1:0]    s_r;
  logic [PAGE_BITS:0]      e_r, cnt_r;
  logic [CW-1:0]           total_r;
  logic [CW-1:0]           idx_r;
  logic [PAGE_BITS+1:0]    used_r;
  logic [PAGE_BITS:0]      free_r, top_r;
  logic [PAGE_BITS-1:0]    base_r;
  logic [1:0]              status_r;
  logic [PAGE_BITS-1:0]    ns_r;
  logic [PAGE_BITS:0]      ne_r;
  logic                    drop_r, app_r;
  logic [PAGE_BITS-1:0]    as_r;
  logic [PAGE_BITS:0]      ae_r;

  logic                    we;
  logic [AW-1:0]           waddr, raddr;
  logic [EW-1:0]           wdata, rdata;
  logic [PAGE_BITS-1:0]    x_s;
  logic [PAGE_BITS:0]      x_e, x_n;

  assign x_s = rdata[PAGE_BITS-1:0];
  assign x_e = rdata[EW-1:PAGE_BITS];
  assign x_n = x_e - {1'b0, x_s};

  pea_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  always_comb begin
    we    = 1'b0;
    waddr = idx_r[AW-1:0];
    wdata = {ne_r, ns_r};
    raddr = idx_r[AW-1:0];
    unique case (state_r)
      S_SCAN_RD: raddr = AW'(idx_r - CW'(1));
      S_WR: we = 1'b1;
      S_APPEND: begin
        we    = 1'b1;
        waddr = total_r[AW-1:0];
        wdata = {ae_r, as_r};
      end
      S_SHIFT_RD: raddr = AW'(idx_r + CW'(1));
      S_SHIFT_WR: begin
        we    = 1'b1;
        wdata = rdata;
      end
      default: ;
    endcase
  end

  assign req_ready  = (state_r == S_IDLE) && !rsp_valid;
  assign rsp_base   = base_r;
  assign rsp_status = status_r;
  assign rsp_used   = used_r;
  assign rsp_free   = free_r;
  assign rsp_top    = top_r;

  // The claimed region may run past the page range, so its end keeps a carry bit.
  logic [PAGE_BITS+1:0] stop;
  logic [PAGE_BITS:0]   len;
  logic [PAGE_BITS-1:0] free_s;
  logic [PAGE_BITS:0]   free_e;
  logic                 claim_hit, claim_tail;
  assign stop       = {2'b00, s_r} + {1'b0, cnt_r};
  assign len        = e_r - {1'b0, s_r};
  assign free_s     = (req_start == '0) ? PAGE_BITS'(1) : req_start;
  assign free_e     = (req_end > PAGE_LIMIT) ? PAGE_LIMIT : req_end;
  assign claim_hit  = ({1'b0, x_e} >= stop) && (x_s <= s_r);
  assign claim_tail = ({1'b0, x_e} > stop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      total_r   <= '0;
      used_r    <= '0;
      free_r    <= '0;
      top_r     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (req_valid && req_ready) begin
            kind_r   <= req_kind;
            cnt_r    <= req_count;
            base_r   <= '0;
            drop_r   <= 1'b0;
            app_r    <= 1'b0;
            idx_r    <= total_r;
            unique case (kind_t'(req_kind))
              KIND_ALLOC: begin
                s_r      <= req_start;
                status_r <= ST_NOFIT;
                state_r  <= S_SCAN_RD;
              end
              KIND_CLAIM: begin
                s_r <= req_start;
                if (req_start == '0) begin
                  status_r <= ST_INVALID;
                  state_r  <= S_DONE;
                end else begin
                  status_r <= ST_NOFIT;
                  state_r  <= S_SCAN_RD;
                end
              end
              KIND_FREE: begin
                s_r <= free_s;
                e_r <= free_e;
                if ({1'b0, free_s} >= free_e) begin
                  status_r <= ST_INVALID;
                  state_r  <= S_DONE;
                end else begin
                  status_r <= ST_OK;
                  state_r  <= S_SCAN_RD;
                end
              end
              default: begin
                used_r   <= '0;
                status_r <= ST_OK;
                state_r  <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN_RD: begin
          if (idx_r == '0) begin
            // No hit anywhere in the table.
            if (kind_r == KIND_FREE) begin
              if (total_r >= CW'(TABLE_DEPTH)) begin
                status_r <= ST_FULL;
                state_r  <= S_DONE;
              end else begin
                as_r    <= s_r;
                ae_r    <= e_r;
                state_r <= S_APPEND;
              end
            end else state_r <= S_DONE;
          end else begin
            idx_r   <= idx_r - CW'(1);
            state_r <= S_SCAN_CHK;
          end
        end
        S_SCAN_CHK: begin
          unique case (kind_t'(kind_r))
            KIND_ALLOC: begin
              if (x_n >= cnt_r) begin
                base_r   <= x_s;
                status_r <= ST_OK;
                ns_r     <= PAGE_BITS'({1'b0, x_s} + cnt_r);
                ne_r     <= x_e;
                drop_r   <= (x_n == cnt_r);
                used_r   <= used_r + (PAGE_BITS+2)'(cnt_r);
                free_r   <= free_r - cnt_r;
                state_r  <= S_WR;
              end else state_r <= S_SCAN_RD;
            end
            KIND_CLAIM: begin
              if (!claim_hit) state_r <= S_SCAN_RD;
              else if (x_s != s_r && claim_tail && total_r >= CW'(TABLE_DEPTH)) begin
                status_r <= ST_FULL;
                state_r  <= S_DONE;
              end else begin
                base_r   <= s_r;
                status_r <= ST_OK;
                used_r   <= used_r + (PAGE_BITS+2)'(cnt_r);
                free_r   <= free_r - cnt_r;
                state_r  <= S_WR;
                if (x_s == s_r) begin
                  ns_r   <= stop[PAGE_BITS-1:0];
                  ne_r   <= x_e;
                  drop_r <= (stop == {1'b0, x_e});
                end else begin
                  ns_r  <= x_s;
                  ne_r  <= {1'b0, s_r};
                  app_r <= claim_tail;
                  as_r  <= stop[PAGE_BITS-1:0];
                  ae_r  <= x_e;
                end
              end
            end
            default: begin
              if ({1'b0, x_s} == e_r) begin
                ns_r    <= s_r;
                ne_r    <= x_e;
                state_r <= S_WR;
              end else if (x_e == {1'b0, s_r}) begin
                ns_r    <= x_s;
                ne_r    <= e_r;
                state_r <= S_WR;
              end else state_r <= S_SCAN_RD;
            end
          endcase
        end
        S_WR: begin
          if (kind_r == KIND_FREE) begin
            if (top_r < e_r) top_r <= e_r;
            used_r <= used_r - (PAGE_BITS+2)'(len);
            free_r <= free_r + len;
            state_r <= S_DONE;
          end else if (app_r) state_r <= S_APPEND;
          else if (drop_r) state_r <= S_SHIFT_RD;
          else state_r <= S_DONE;
        end
        S_APPEND: begin
          total_r <= total_r + CW'(1);
          if (kind_r == KIND_FREE) begin
            if (top_r < e_r) top_r <= e_r;
            used_r <= used_r - (PAGE_BITS+2)'(len);
            free_r <= free_r + len;
          end
          state_r <= S_DONE;
        end
        S_SHIFT_RD: begin
          if (idx_r + CW'(1) >= total_r) begin
            total_r <= total_r - CW'(1);
            state_r <= S_DONE;
          end else state_r <= S_SHIFT_WR;
        end
        S_SHIFT_WR: begin
          idx_r   <= idx_r + CW'(1);
          state_r <= S_SHIFT_RD;
        end
        default: begin
          rsp_valid <= 1'b1;
          state_r   <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/page_extent_allocator_top.sv
`default_nettype none
// Page extent allocator: keeps up to TABLE_DEPTH free extents in one
// synchronous RAM and serves allocate, claim, free and reset-used requests.
// A request beat arrives on the in_ channel; exactly one result beat leaves
// on the out_ channel for each request. Requests are handled one at a time.
// The table is scanned newest entry first, through a read state and a check
// state per entry; when an extent is removed, each entry above it is shifted
// down through a read state and a write state. The single RAM port pair
// allows one read and one write per cycle.
// Reset empties the table and clears the used, free and highest counters;
// table contents need no clearing since only live entries are read.
// When the receiver stalls, the result is held in the output register and
// in_tready stays low until the result beat is taken.
// A free merges with one adjacent extent or appends a new one; a full table
// gives the table-full status and leaves all state unchanged.
module page_extent_allocator_top
  import pea_pkg::*;
#(
  parameter int TABLE_DEPTH = 128,
  parameter int PAGE_BITS   = 40
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // kind[1:0], start_page[PB+1:2], end_page, page_count, zero fill
  input  wire logic [((2 + PAGE_BITS + 2*(PAGE_BITS+1)) + 7)/8*8-1:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // base_page, status, used_count, free_count, highest_page, zero fill
  output logic [((PAGE_BITS + 2 + PAGE_BITS+2 + 2*(PAGE_BITS+1)) + 7)/8*8-1:0] out_tdata
);
  localparam int OW = ((PAGE_BITS + 2 + PAGE_BITS+2 + 2*(PAGE_BITS+1)) + 7)/8*8;
  localparam int IU = 2 + PAGE_BITS + 2*(PAGE_BITS+1);

  logic [PAGE_BITS-1:0] base;
  logic [1:0]           status;
  logic [PAGE_BITS+1:0] used;
  logic [PAGE_BITS:0]   free_cnt, top;

  pea_engine #(.TABLE_DEPTH(TABLE_DEPTH), .PAGE_BITS(PAGE_BITS)) u_engine (
    .clk(clk), .rst_n(rst_n),
    .req_valid(in_tvalid), .req_ready(in_tready),
    .req_kind(in_tdata[1:0]),
    .req_start(in_tdata[PAGE_BITS+1:2]),
    .req_end(in_tdata[2*PAGE_BITS+2:PAGE_BITS+2]),
    .req_count(in_tdata[IU-1:2*PAGE_BITS+3]),
    .rsp_valid(out_tvalid), .rsp_ready(out_tready),
    .rsp_base(base), .rsp_status(status), .rsp_used(used),
    .rsp_free(free_cnt), .rsp_top(top)
  );

  assign out_tdata = OW'({top, free_cnt, used, status, base});
endmodule
`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import pea_pkg::*;

  localparam int DEPTH = 128;
  localparam longint unsigned PAGE_LIM = 64'd1 << 40;
  localparam longint unsigned PAGE_MSK = PAGE_LIM - 1;
  localparam longint unsigned END_MSK = (64'd1 << 41) - 1;
  localparam longint unsigned USED_MSK = (64'd1 << 42) - 1;
  localparam int CYCLE_LIMIT = 5000000;
  localparam int HOLD_LEN = 800;

  // One result beat, split into fields; the last field sits in the lowest bits.
  typedef struct packed {
    logic [40:0] highest_page;
    logic [40:0] free_count;
    logic [41:0] used_count;
    status_t     status;
    logic [39:0] base_page;
  } alloc_result_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  // kind, start_page, end_page, page_count, zero fill (lowest bit up)
  logic [127:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // base_page, status, used_count, free_count, highest_page, zero fill
  logic [167:0] out_tdata;

  page_extent_allocator_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // Shadow copy of the free-extent table and the counters.
  longint unsigned ext_lo[DEPTH];
  longint unsigned ext_hi[DEPTH];
  longint unsigned ext_len[DEPTH];
  int unsigned     ext_cnt;
  longint unsigned pages_used;
  longint unsigned pages_free;
  longint unsigned top_freed;

  alloc_result_t expected_results[$];
  int errors = 0;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles = 0;
  int hold_asked = 0;
  int hold_seen = 0;
  longint cycles = 0;

  initial begin
    clk = 1'b0;
  end
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Removes one extent and closes the gap above it.
  function automatic void remove_extent(int unsigned i);
    while (i + 1 < ext_cnt) begin
      ext_lo[i] = ext_lo[i + 1];
      ext_hi[i] = ext_hi[i + 1];
      ext_len[i] = ext_len[i + 1];
      i++;
    end
    if (ext_cnt != 0) ext_cnt--;
  endfunction

  function automatic void add_extent(longint unsigned s, longint unsigned e);
    if (e <= s || ext_cnt >= DEPTH) return;
    ext_lo[ext_cnt] = s & PAGE_MSK;
    ext_hi[ext_cnt] = e & END_MSK;
    ext_len[ext_cnt] = (e - s) & END_MSK;
    ext_cnt++;
  endfunction

  // Applies one request to the shadow state and returns the result it gives.
  function automatic alloc_result_t apply_request(kind_t kind, longint unsigned sp,
                                                  longint unsigned ep,
                                                  longint unsigned cnt);
    alloc_result_t r;
    longint unsigned base;
    longint unsigned stop;
    longint unsigned s;
    longint unsigned e;
    longint unsigned len;
    longint unsigned old_end;
    status_t st;
    bit hit;
    int i;
    base = 0;
    st = ST_OK;
    hit = 1'b0;
    case (kind)
      KIND_ALLOC: begin
        for (i = int'(ext_cnt) - 1; i >= 0; i--) begin
          if (ext_len[i] >= cnt) begin
            base = ext_lo[i];
            ext_lo[i] = (ext_lo[i] + cnt) & PAGE_MSK;
            ext_len[i] -= cnt;
            if (ext_len[i] == 0) remove_extent(i);
            hit = 1'b1;
            break;
          end
        end
        if (hit) begin
          pages_used = (pages_used + cnt) & USED_MSK;
          pages_free = (pages_free - cnt) & END_MSK;
        end else begin
          st = ST_NOFIT;
        end
      end
      KIND_CLAIM: begin
        stop = sp + cnt;
        if (sp == 0) begin
          st = ST_INVALID;
        end else begin
          st = ST_NOFIT;
          for (i = int'(ext_cnt) - 1; i >= 0; i--) begin
            if (ext_hi[i] >= stop && ext_lo[i] <= sp) begin
              if (ext_lo[i] == sp) begin
                ext_lo[i] = stop & PAGE_MSK;
                ext_len[i] = ext_hi[i] - stop;
              end else begin
                old_end = ext_hi[i];
                if (old_end > stop && ext_cnt >= DEPTH) begin
                  st = ST_FULL;
                  break;
                end
                ext_hi[i] = sp;
                ext_len[i] = sp - ext_lo[i];
                add_extent(stop, old_end);
              end
              if (ext_len[i] == 0) remove_extent(i);
              pages_used = (pages_used + cnt) & USED_MSK;
              pages_free = (pages_free - cnt) & END_MSK;
              base = sp;
              st = ST_OK;
              break;
            end
          end
        end
      end
      KIND_FREE: begin
        s = (sp != 0) ? sp : 1;
        e = (ep > PAGE_LIM) ? PAGE_LIM : ep;
        if (s >= e) begin
          st = ST_INVALID;
        end else begin
          len = e - s;
          for (i = int'(ext_cnt) - 1; i >= 0; i--) begin
            if (ext_lo[i] == e) ext_lo[i] = s;
            else if (ext_hi[i] == s) ext_hi[i] = e;
            else continue;
            ext_len[i] = (ext_len[i] + len) & END_MSK;
            hit = 1'b1;
            break;
          end
          if (!hit && ext_cnt >= DEPTH) begin
            st = ST_FULL;
          end else begin
            if (!hit) add_extent(s, e);
            if (top_freed < e) top_freed = e;
            pages_used = (pages_used - len) & USED_MSK;
            pages_free = (pages_free + len) & END_MSK;
          end
        end
      end
      default: pages_used = 0;
    endcase
    r.base_page = base[39:0];
    r.status = st;
    r.used_count = pages_used[41:0];
    r.free_count = pages_free[40:0];
    r.highest_page = top_freed[40:0];
    return r;
  endfunction

  // Offers one request beat and returns once it has been accepted. The
  // expectation is queued at the accepting edge, before any result can leave.
  task automatic send_request(kind_t kind, logic [39:0] sp, logic [40:0] ep,
                              logic [40:0] cnt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, cnt, ep, sp, kind};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_results.push_back(apply_request(kind, sp, ep, cnt));
  endtask

  task automatic end_stimulus();
    in_tvalid <= 1'b0;
  endtask

  function automatic logic [40:0] rand41();
    return 41'({$urandom(), $urandom()});
  endfunction

  // Receiver: random stalls, plus a long hold-off whenever one is asked for.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else if (hold_seen != hold_asked) begin
      hold_seen <= hold_asked;
      hold_cycles <= HOLD_LEN;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result checker: compares each accepted result beat with the oldest expectation.
  always @(posedge clk) begin
    alloc_result_t got;
    alloc_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[165:0];
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected: %h", $time, got);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (got.base_page !== want.base_page) begin
          $display("%0t: base_page expected %h actual %h", $time, want.base_page,
                   got.base_page);
          errors++;
        end
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          errors++;
        end
        if (got.used_count !== want.used_count) begin
          $display("%0t: used_count expected %h actual %h", $time, want.used_count,
                   got.used_count);
          errors++;
        end
        if (got.free_count !== want.free_count) begin
          $display("%0t: free_count expected %h actual %h", $time, want.free_count,
                   got.free_count);
          errors++;
        end
        if (got.highest_page !== want.highest_page) begin
          $display("%0t: highest_page expected %h actual %h", $time, want.highest_page,
                   got.highest_page);
          errors++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Edge cases: empty table, zero sizes, saturation and invalid ranges.
  task automatic test_directed();
    send_request(KIND_ALLOC, 40'd0, 41'd0, 41'd0);
    send_request(KIND_ALLOC, 40'd0, 41'd0, 41'd5);
    send_request(KIND_CLAIM, 40'd0, 41'd0, 41'd1);
    send_request(KIND_CLAIM, 40'd10, 41'd0, 41'd1);
    send_request(KIND_FREE, 40'd7, 41'd7, 41'd0);
    send_request(KIND_FREE, 40'd9, 41'd3, 41'd0);
    send_request(KIND_FREE, 40'd0, 41'd100, 41'd0);
    send_request(KIND_FREE, 40'd100, 41'd200, 41'd0);
    send_request(KIND_FREE, 40'd300, 41'd400, 41'd0);
    send_request(KIND_FREE, 40'd200, 41'd300, 41'd0);
    send_request(KIND_ALLOC, 40'd0, 41'd0, 41'd0);
    send_request(KIND_CLAIM, 40'd50, 41'd0, 41'd10);
    send_request(KIND_CLAIM, 40'd1, 41'd0, 41'd5);
    send_request(KIND_CLAIM, 40'd60, 41'd0, 41'd340);
    send_request(KIND_ALLOC, 40'd0, 41'd0, 41'd45);
    send_request(KIND_RESET, 40'hff_ffff_ffff, 41'h1ff_ffff_ffff, 41'h1ff_ffff_ffff);
    send_request(KIND_FREE, 40'hff_ffff_ff00, 41'h1ff_ffff_ffff, 41'd0);
    send_request(KIND_FREE, 40'hff_ffff_fff0, 41'h100_0000_0000, 41'd0);
    send_request(KIND_CLAIM, 40'hff_ffff_ff00, 41'd0, 41'h1ff_ffff_ffff);
    send_request(KIND_CLAIM, 40'hff_ffff_ff10, 41'd0, 41'd16);
    send_request(KIND_ALLOC, 40'd0, 41'd0, 41'h1ff_ffff_ffff);
    send_request(KIND_ALLOC, 40'd0, 41'd0, 41'd200);
    send_request(KIND_FREE, 40'd1000, 41'h1ff_ffff_ffff, 41'd0);
    send_request(KIND_RESET, 40'd0, 41'd0, 41'd0);
  endtask

  // Fills the table with separate extents so that free and claim split hit the limit.
  task automatic test_table_full();
    int k;
    for (k = 0; k < DEPTH + 2; k++)
      send_request(KIND_FREE, 40'd5000 + 4 * k, 41'd5002 + 4 * k, 41'd0);
    send_request(KIND_FREE, 40'd4000, 41'd4001, 41'd0);
    send_request(KIND_CLAIM, 40'd5001, 41'd0, 41'd0);
    send_request(KIND_CLAIM, 40'd5000, 41'd0, 41'd1);
    send_request(KIND_CLAIM, 40'd5005, 41'd0, 41'd1);
    for (k = 0; k < DEPTH + 4; k++)
      send_request(KIND_ALLOC, 40'd0, 41'd0, 41'd2);
  endtask

  // Mostly well-formed requests on a small page range, with some wide noise.
  task automatic random_request();
    int pick;
    int unsigned i;
    longint unsigned sp;
    longint unsigned room;
    pick = $urandom_range(99);
    if (pick < 40) begin
      sp = $urandom_range(4000);
      send_request(KIND_FREE, 40'(sp), 41'(sp + $urandom_range(64)), 41'd0);
    end else if (pick < 65) begin
      send_request(KIND_ALLOC, 40'd0, 41'd0, 41'($urandom_range(80)));
    end else if (pick < 88) begin
      if (ext_cnt != 0) begin
        i = $urandom_range(ext_cnt - 1);
        room = ext_hi[i] - ext_lo[i];
        sp = ext_lo[i] + ((room != 0) ? $urandom_range(32'(room - 1)) : 0);
        room = ext_hi[i] - sp;
        send_request(KIND_CLAIM, 40'(sp), 41'd0,
                     41'((room > 64) ? $urandom_range(64) : $urandom_range(32'(room))));
      end else begin
        send_request(KIND_CLAIM, 40'($urandom_range(4000)), 41'd0,
                     41'($urandom_range(40)));
      end
    end else if (pick < 91) begin
      send_request(KIND_RESET, 40'(rand41()), rand41(), rand41());
    end else begin
      send_request(kind_t'($urandom_range(3)), 40'(rand41()), rand41(), rand41());
    end
  endtask

  task automatic test_random(int n);
    repeat (n) random_request();
  endtask

  // A long receiver hold-off while requests keep coming fills the output and
  // stalls the input channel.
  task automatic test_backpressure();
    hold_asked = hold_asked + 1;
    repeat (12) random_request();
  endtask

  initial begin
    send_idle_pct = 32;
    recv_idle_pct = 73;
    ext_cnt = 0;
    pages_used = 0;
    pages_free = 0;
    top_freed = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_table_full();
    test_random(500);
    send_idle_pct = 73;
    recv_idle_pct = 32;
    test_random(450);
    test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(500);
    end_stimulus();

    while (expected_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
